// ===== rtl/tpf_pkg.sv =====
`timescale 1ns / 1ps
package tpf_pkg;

	localparam int FIELD_W = 12;
	localparam int DIM_W = 13;
	localparam int MAX_FIELDS = 5;
	localparam int GROUP_SAMPLES_DEF = 5;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int CFG_IDX_W = 3;
	localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [DIM_W-1:0] dim_t;

	typedef enum logic [2:0] {
		KIND_PEN = 3'd0,
		KIND_Z1  = 3'd1,
		KIND_Z2  = 3'd2,
		KIND_X   = 3'd3,
		KIND_Y   = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESH = 3'd0,
		CFG_X_LOW  = 3'd1,
		CFG_X_HIGH = 3'd2,
		CFG_Y_LOW  = 3'd3,
		CFG_Y_HIGH = 3'd4,
		CFG_WIDTH  = 3'd5,
		CFG_HEIGHT = 3'd6,
		CFG_ORIENT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		field_t lo;
		field_t hi;
		dim_t   dim;
	} axis_cfg_t;

	function automatic dim_t clamp_dim(input dim_t d);
		dim_t r;
		if (d == '0) r = dim_t'(1);
		else if (d > DIM_MAX) r = DIM_MAX;
		else r = d;
		return r;
	endfunction

	function automatic field_t clamp_coord(input logic signed [DIM_W:0] c, input dim_t dim);
		field_t r;
		dim_t dm1;
		dm1 = dim - dim_t'(1);
		if (c < 0) r = '0;
		else if ($unsigned(c) >= {1'b0, dim}) r = dm1[FIELD_W-1:0];
		else r = c[FIELD_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/touch_panel_point_filter.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    kind, pen_down, sample_a..sample_e
// out       output     out_valid/out_ready  pressed, point_x, point_y, pressure_one/two
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each word passes through capture, median and decision states, and through an emit
// state when it yields a result word. A Y group that yields a point adds the axis
// mapping: a direct result when both axes clamp, else a multiply, a 12-step restoring
// divide and a check of the done flags.
// in_ready is high only when the controller is idle; a finished result waits
// in the output register while the next word is taken, and the controller
// holds in its emit state while that register is still full.
// Reset clears FSM, flags and held Z1/Z2/X/point, loads defaults; no clearing pass.
module touch_panel_point_filter #(
	parameter int GROUP_SAMPLES = tpf_pkg::GROUP_SAMPLES_DEF,
	parameter int SAMPLE_BITS = tpf_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] kind,
	input  logic pen_down,
	input  logic [11:0] sample_a,
	input  logic [11:0] sample_b,
	input  logic [11:0] sample_c,
	input  logic [11:0] sample_d,
	input  logic [11:0] sample_e,
	output logic out_valid,
	input  logic out_ready,
	output logic pressed,
	output logic [11:0] point_x,
	output logic [11:0] point_y,
	output logic [11:0] pressure_one,
	output logic [11:0] pressure_two,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [12:0] cfg_data
);
	localparam int FW = tpf_pkg::FIELD_W;
	localparam int DW = tpf_pkg::DIM_W;

	typedef enum logic [2:0] {S_IDLE, S_MED, S_ACT, S_MAP, S_EMIT} state_t;

	state_t state_q;
	tpf_pkg::field_t thr_q, xlo_q, xhi_q, ylo_q, yhi_q;
	tpf_pkg::dim_t wid_q, hgt_q;
	logic [5:0] orient_q;

	logic [2:0] kind_q;
	logic pen_q;
	tpf_pkg::field_t smp_q [tpf_pkg::MAX_FIELDS];
	tpf_pkg::field_t med, med_q;
	tpf_pkg::field_t z1_q, z2_q, xmed_q, col_q, row_q;
	logic press_q;
	logic res_p_q;
	tpf_pkg::field_t res_z1_q, res_z2_q;

	logic out_valid_q, out_p_q;
	tpf_pkg::field_t out_x_q, out_y_q, out_z1_q, out_z2_q;

	tpf_pkg::dim_t w, h, mxd, myd;
	tpf_pkg::field_t rx, ry, cx, cy, ix, iy;
	logic signed [DW:0] sx, sy, px, py, mx, my;
	logic go, ps, done_x, done_y;
	tpf_pkg::axis_cfg_t xcfg, ycfg;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign pressed = out_p_q;
	assign point_x = out_x_q;
	assign point_y = out_y_q;
	assign pressure_one = out_z1_q;
	assign pressure_two = out_z2_q;

	tpf_median #(.GROUP_SAMPLES(GROUP_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_median (
		.smp(smp_q),
		.med(med)
	);

	assign w = tpf_pkg::clamp_dim(wid_q);
	assign h = tpf_pkg::clamp_dim(hgt_q);
	assign mxd = w - tpf_pkg::dim_t'(1);
	assign myd = h - tpf_pkg::dim_t'(1);
	assign rx = orient_q[0] ? med_q : xmed_q;
	assign ry = orient_q[0] ? xmed_q : med_q;
	assign go = (state_q == S_ACT) && (kind_q == tpf_pkg::KIND_Y) && press_q;
	assign ps = (z1_q >= thr_q) && (med_q > z1_q);
	assign xcfg = '{lo: xlo_q, hi: xhi_q, dim: w};
	assign ycfg = '{lo: ylo_q, hi: yhi_q, dim: h};

	tpf_axis_map u_map_x (
		.clk(clk), .arst_n(arst_n), .start(go), .v(rx), .acfg(xcfg),
		.done(done_x), .coord(cx)
	);
	tpf_axis_map u_map_y (
		.clk(clk), .arst_n(arst_n), .start(go), .v(ry), .acfg(ycfg),
		.done(done_y), .coord(cy)
	);

	always_comb begin
		ix = orient_q[1] ? (mxd[FW-1:0] - cx) : cx;
		iy = orient_q[2] ? (myd[FW-1:0] - cy) : cy;
		px = $signed({2'b00, ix});
		py = $signed({2'b00, iy});
		mx = $signed({1'b0, mxd});
		my = $signed({1'b0, myd});
		case (orient_q[4:3])
			2'd1: begin
				sx = mx - py;
				sy = px;
			end
			2'd2: begin
				sx = mx - px;
				sy = my - py;
			end
			2'd3: begin
				sx = py;
				sy = my - px;
			end
			default: begin
				sx = px;
				sy = py;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			xlo_q <= '0;
			xhi_q <= 12'd4095;
			ylo_q <= '0;
			yhi_q <= 12'd4095;
			wid_q <= 13'd320;
			hgt_q <= 13'd240;
			orient_q <= '0;
		end else if (cfg_valid) begin
			unique case (tpf_pkg::cfg_idx_t'(cfg_index))
				tpf_pkg::CFG_THRESH: thr_q <= cfg_data[FW-1:0];
				tpf_pkg::CFG_X_LOW:  xlo_q <= cfg_data[FW-1:0];
				tpf_pkg::CFG_X_HIGH: xhi_q <= cfg_data[FW-1:0];
				tpf_pkg::CFG_Y_LOW:  ylo_q <= cfg_data[FW-1:0];
				tpf_pkg::CFG_Y_HIGH: yhi_q <= cfg_data[FW-1:0];
				tpf_pkg::CFG_WIDTH:  wid_q <= cfg_data;
				tpf_pkg::CFG_HEIGHT: hgt_q <= cfg_data;
				tpf_pkg::CFG_ORIENT: orient_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			z1_q <= '0;
			z2_q <= '0;
			xmed_q <= '0;
			col_q <= '0;
			row_q <= '0;
			press_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						pen_q <= pen_down;
						smp_q[0] <= sample_a;
						smp_q[1] <= sample_b;
						smp_q[2] <= sample_c;
						smp_q[3] <= sample_d;
						smp_q[4] <= sample_e;
						state_q <= S_MED;
					end
				end
				S_MED: begin
					med_q <= med;
					state_q <= S_ACT;
				end
				S_ACT: begin
					state_q <= S_IDLE;
					res_p_q <= 1'b0;
					case (kind_q)
						tpf_pkg::KIND_PEN: begin
							press_q <= 1'b0;
							if (orient_q[5] && !pen_q) begin
								res_z1_q <= '0;
								res_z2_q <= '0;
								state_q <= S_EMIT;
							end
						end
						tpf_pkg::KIND_Z1: begin
							z1_q <= med_q;
							press_q <= 1'b0;
						end
						tpf_pkg::KIND_Z2: begin
							z2_q <= med_q;
							press_q <= ps;
							if (!ps) begin
								res_z1_q <= z1_q;
								res_z2_q <= med_q;
								state_q <= S_EMIT;
							end
						end
						tpf_pkg::KIND_X: xmed_q <= med_q;
						tpf_pkg::KIND_Y: begin
							if (press_q) begin
								press_q <= 1'b0;
								state_q <= S_MAP;
							end
						end
						default: ;
					endcase
				end
				S_MAP: begin
					if (done_x && done_y) begin
						col_q <= tpf_pkg::clamp_coord(sx, w);
						row_q <= tpf_pkg::clamp_coord(sy, h);
						res_p_q <= 1'b1;
						res_z1_q <= z1_q;
						res_z2_q <= z2_q;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_p_q <= res_p_q;
						out_x_q <= col_q;
						out_y_q <= row_q;
						out_z1_q <= res_z1_q;
						out_z2_q <= res_z2_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/tpf_median_lane.sv =====
`timescale 1ns / 1ps
module tpf_median_lane #(
	parameter int NS = 5,
	parameter int LANE = 0
) (
	input  tpf_pkg::field_t smp [NS],
	output logic [$clog2(NS)-1:0] rank
);
	localparam int RW = $clog2(NS);

	always_comb begin
		rank = '0;
		for (int j = 0; j < NS; j++) begin
			if (j < LANE) begin
				if (smp[j] <= smp[LANE]) rank = rank + RW'(1);
			end else if (j > LANE) begin
				if (smp[j] < smp[LANE]) rank = rank + RW'(1);
			end
		end
	end
endmodule

// ===== rtl/tpf_median.sv =====
`timescale 1ns / 1ps
module tpf_median #(
	parameter int GROUP_SAMPLES = tpf_pkg::GROUP_SAMPLES_DEF,
	parameter int SAMPLE_BITS = tpf_pkg::SAMPLE_BITS_DEF
) (
	input  tpf_pkg::field_t smp [tpf_pkg::MAX_FIELDS],
	output tpf_pkg::field_t med
);
	localparam int NS = (GROUP_SAMPLES < tpf_pkg::MAX_FIELDS) ? GROUP_SAMPLES
		: tpf_pkg::MAX_FIELDS;
	localparam int RW = $clog2(NS);
	localparam int MB = (SAMPLE_BITS < tpf_pkg::FIELD_W) ? SAMPLE_BITS : tpf_pkg::FIELD_W;
	localparam tpf_pkg::field_t SMASK = tpf_pkg::FIELD_W'((64'd1 << MB) - 64'd1);

	tpf_pkg::field_t v [NS];
	logic [RW-1:0] rank [NS];

	always_comb begin
		for (int i = 0; i < NS; i++) v[i] = smp[i] & SMASK;
	end

	for (genvar g = 0; g < NS; g++) begin : g_lane
		tpf_median_lane #(.NS(NS), .LANE(g)) u_lane (.smp(v), .rank(rank[g]));
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < NS; i++) begin
			if (rank[i] == RW'(NS / 2)) med = med | v[i];
		end
	end
endmodule

// ===== rtl/tpf_axis_map.sv =====
`timescale 1ns / 1ps
module tpf_axis_map (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  tpf_pkg::field_t v,
	input  tpf_pkg::axis_cfg_t acfg,
	output logic done,
	output tpf_pkg::field_t coord
);
	localparam int FW = tpf_pkg::FIELD_W;
	localparam int CW = $clog2(FW);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

	mstate_t state_q;
	logic done_q;
	tpf_pkg::field_t diff_q, den_q, dm1_q, rem_q, low_q, coord_q;
	logic [CW-1:0] cnt_q;
	logic [2*FW-1:0] prod;
	logic [FW:0] trial;
	tpf_pkg::dim_t dm1;

	assign dm1 = acfg.dim - tpf_pkg::dim_t'(1);
	assign prod = diff_q * dm1_q;
	assign trial = {rem_q, low_q[FW-1]};
	assign done = done_q;
	assign coord = coord_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						done_q <= 1'b1;
						if (acfg.hi <= acfg.lo) begin
							coord_q <= ({1'b0, v} < acfg.dim) ? v : dm1[FW-1:0];
						end else if (v <= acfg.lo) begin
							coord_q <= '0;
						end else if (v >= acfg.hi) begin
							coord_q <= dm1[FW-1:0];
						end else begin
							done_q <= 1'b0;
							diff_q <= v - acfg.lo;
							den_q <= acfg.hi - acfg.lo;
							dm1_q <= dm1[FW-1:0];
							state_q <= M_MUL;
						end
					end
				end
				M_MUL: begin
					rem_q <= prod[2*FW-1:FW];
					low_q <= prod[FW-1:0];
					cnt_q <= '0;
					state_q <= M_DIV;
				end
				M_DIV: begin
					if (trial >= {1'b0, den_q}) begin
						rem_q <= FW'(trial - {1'b0, den_q});
						low_q <= {low_q[FW-2:0], 1'b1};
					end else begin
						rem_q <= trial[FW-1:0];
						low_q <= {low_q[FW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(FW - 1)) begin
						state_q <= M_IDLE;
						done_q <= 1'b1;
						coord_q <= {low_q[FW-2:0], (trial >= {1'b0, den_q})};
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/tpf_checker.sv =====
`timescale 1ns / 1ps
module tpf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pressed,
	input logic [11:0] point_x,
	input logic [11:0] point_y,
	input logic [11:0] pressure_one,
	input logic [11:0] pressure_two,
	input logic cfg_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressed) && $stable(point_x)
			&& $stable(point_y) && $stable(pressure_one) && $stable(pressure_two))
		else $error("result word changed while stalled");

	a_press_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressed |-> pressure_two > pressure_one)
		else $error("pressed word without Z2 above Z1");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result word right after accept");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule

bind touch_panel_point_filter tpf_checker u_tpf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .pressed(pressed),
	.point_x(point_x), .point_y(point_y), .pressure_one(pressure_one),
	.pressure_two(pressure_two), .cfg_ready(cfg_ready)
);

// ===== tb/touch_point_checker.sv =====
`timescale 1ns / 1ps
module touch_point_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [2:0] kind,
	input  logic pen_down,
	input  logic [11:0] sample_a,
	input  logic [11:0] sample_b,
	input  logic [11:0] sample_c,
	input  logic [11:0] sample_d,
	input  logic [11:0] sample_e,
	input  logic out_valid,
	input  logic out_ready,
	input  logic pressed,
	input  logic [11:0] point_x,
	input  logic [11:0] point_y,
	input  logic [11:0] pressure_one,
	input  logic [11:0] pressure_two,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [12:0] cfg_data,
	output int errors,
	output int points_waiting,
	output int reports_seen,
	output int presses_seen
);

	typedef struct {
		logic   down;
		tpf_pkg::field_t col;
		tpf_pkg::field_t row;
		tpf_pkg::field_t z1;
		tpf_pkg::field_t z2;
	} touch_report_t;

	touch_report_t expected_reports[$];

	tpf_pkg::field_t thresh, x_lo, x_hi, y_lo, y_hi;
	tpf_pkg::dim_t width, height;
	logic [5:0] orient;
	tpf_pkg::field_t z1_med, z2_med, x_med, last_col, last_row;
	logic touch_armed;

	function automatic tpf_pkg::field_t median5(input tpf_pkg::field_t a, b, c, d, e);
		tpf_pkg::field_t v[5];
		tpf_pkg::field_t t;
		v = '{a, b, c, d, e};
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 4 - i; j++)
				if (v[j] > v[j+1]) begin
					t = v[j];
					v[j] = v[j+1];
					v[j+1] = t;
				end
		return v[2];
	endfunction

	function automatic int unsigned legal_dim(input tpf_pkg::dim_t d);
		if (d == 0) return 1;
		if (d > 4096) return 4096;
		return 32'(d);
	endfunction

	function automatic int scale_axis(input int unsigned v, lo, hi, dim);
		if (hi <= lo) return int'((v < dim) ? v : dim - 1);
		if (v <= lo) return 0;
		if (v >= hi) return int'(dim - 1);
		return int'(((v - lo) * (dim - 1)) / (hi - lo));
	endfunction

	function automatic tpf_pkg::field_t fit_screen(input int c, input int unsigned dim);
		if (c < 0) return '0;
		if (c >= int'(dim)) return tpf_pkg::field_t'(dim - 1);
		return tpf_pkg::field_t'(c);
	endfunction

	function automatic void emit_report(input logic down, input tpf_pkg::field_t z1, z2);
		touch_report_t r;
		r.down = down;
		r.col = last_col;
		r.row = last_row;
		r.z1 = z1;
		r.z2 = z2;
		expected_reports.push_back(r);
	endfunction

	function automatic void track_word();
		tpf_pkg::field_t med, rx, ry;
		int unsigned w, h;
		int x, y, px, py;
		med = median5(sample_a, sample_b, sample_c, sample_d, sample_e);
		case (kind)
			tpf_pkg::KIND_PEN: begin
				touch_armed = 1'b0;
				if (orient[5] && !pen_down) emit_report(1'b0, '0, '0);
			end
			tpf_pkg::KIND_Z1: begin
				z1_med = med;
				touch_armed = 1'b0;
			end
			tpf_pkg::KIND_Z2: begin
				z2_med = med;
				touch_armed = (z1_med >= thresh) && (z2_med > z1_med);
				if (!touch_armed) emit_report(1'b0, z1_med, z2_med);
			end
			tpf_pkg::KIND_X: x_med = med;
			tpf_pkg::KIND_Y: begin
				if (touch_armed) begin
					touch_armed = 1'b0;
					rx = orient[0] ? med : x_med;
					ry = orient[0] ? x_med : med;
					w = legal_dim(width);
					h = legal_dim(height);
					x = scale_axis(rx, x_lo, x_hi, w);
					y = scale_axis(ry, y_lo, y_hi, h);
					if (orient[1]) x = int'(w) - 1 - x;
					if (orient[2]) y = int'(h) - 1 - y;
					px = x;
					py = y;
					case (orient[4:3])
						2'd1: begin
							x = int'(w) - 1 - py;
							y = px;
						end
						2'd2: begin
							x = int'(w) - 1 - px;
							y = int'(h) - 1 - py;
						end
						2'd3: begin
							x = py;
							y = int'(h) - 1 - px;
						end
						default: ;
					endcase
					last_col = fit_screen(x, w);
					last_row = fit_screen(y, h);
					emit_report(1'b1, z1_med, z2_med);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh <= '0;
			x_lo <= '0;
			x_hi <= 12'd4095;
			y_lo <= '0;
			y_hi <= 12'd4095;
			width <= 13'd320;
			height <= 13'd240;
			orient <= '0;
			z1_med <= '0;
			z2_med <= '0;
			x_med <= '0;
			last_col <= '0;
			last_row <= '0;
			touch_armed <= 1'b0;
			expected_reports.delete();
			errors <= 0;
			reports_seen <= 0;
			presses_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tpf_pkg::CFG_THRESH: thresh = cfg_data[11:0];
					tpf_pkg::CFG_X_LOW:  x_lo = cfg_data[11:0];
					tpf_pkg::CFG_X_HIGH: x_hi = cfg_data[11:0];
					tpf_pkg::CFG_Y_LOW:  y_lo = cfg_data[11:0];
					tpf_pkg::CFG_Y_HIGH: y_hi = cfg_data[11:0];
					tpf_pkg::CFG_WIDTH:  width = cfg_data;
					tpf_pkg::CFG_HEIGHT: height = cfg_data;
					tpf_pkg::CFG_ORIENT: orient = cfg_data[5:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) track_word();
			if (out_valid && out_ready) begin
				touch_report_t e;
				reports_seen++;
				if (pressed) presses_seen++;
				if (expected_reports.size() == 0) begin
					report_mismatch("reports pending", 1, 0);
				end else begin
					e = expected_reports.pop_front();
					if (pressed !== e.down) report_mismatch("pressed", pressed, e.down);
					if (point_x !== e.col) report_mismatch("point_x", point_x, e.col);
					if (point_y !== e.row) report_mismatch("point_y", point_y, e.row);
					if (pressure_one !== e.z1) report_mismatch("pressure_one", pressure_one, e.z1);
					if (pressure_two !== e.z2) report_mismatch("pressure_two", pressure_two, e.z2);
				end
			end
		end
	end

	assign points_waiting = expected_reports.size();

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 30;

	logic clk, arst_n;
	logic in_valid, in_ready, pen_down;
	logic [2:0] kind;
	logic [11:0] sample_a, sample_b, sample_c, sample_d, sample_e;
	logic out_valid, out_ready, pressed;
	logic [11:0] point_x, point_y, pressure_one, pressure_two;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [12:0] cfg_data;
	int errors, points_waiting, reports_seen, presses_seen;
	int words_sent, idle_cycles;
	bit steady, hold_output;
	tpf_pkg::field_t cur_thresh;

	touch_panel_point_filter dut (.*);
	touch_point_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int n;
		bit stretched;
		stretched = 1'b0;
		out_ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_output && !stretched) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				stretched = 1'b1;
			end else begin
				n = steady ? 0 : $urandom_range(0, 8);
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_word(input logic [2:0] k, input logic pd,
			input tpf_pkg::field_t a, b, c, d, e);
		int n;
		n = steady ? 0 : $urandom_range(0, 8);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		pen_down <= pd;
		sample_a <= a;
		sample_b <= b;
		sample_c <= c;
		sample_d <= d;
		sample_e <= e;
		do @(posedge clk); while (!(in_valid && in_ready));
		if (k <= tpf_pkg::KIND_Y) words_sent++;
	endtask

	task automatic send_flat(input logic [2:0] k, input tpf_pkg::field_t v);
		send_word(k, 1'b1, v, v, v, v, v);
	endtask

	function automatic tpf_pkg::field_t jitter(input tpf_pkg::field_t c);
		int v;
		v = int'(c) + int'($urandom_range(0, 40)) - 20;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return tpf_pkg::field_t'(v);
	endfunction

	function automatic tpf_pkg::field_t any_sample();
		return tpf_pkg::field_t'($urandom);
	endfunction

	function automatic logic any_pen();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_group(input logic [2:0] k, input tpf_pkg::field_t c);
		if ($urandom_range(0, 7) == 0)
			send_word(k, any_pen(), any_sample(), any_sample(), any_sample(), any_sample(),
				any_sample());
		else
			send_word(k, any_pen(), jitter(c), jitter(c), jitter(c), jitter(c),
				jitter(c));
	endtask

	task automatic write_reg(input tpf_pkg::cfg_idx_t idx, input logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (idx == tpf_pkg::CFG_THRESH) cur_thresh = val[11:0];
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (points_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_setup(input tpf_pkg::field_t th, xl, xh, yl, yh,
			input logic [12:0] w, h, input logic [5:0] o);
		write_reg(tpf_pkg::CFG_THRESH, {1'b0, th});
		write_reg(tpf_pkg::CFG_X_LOW, {1'b0, xl});
		write_reg(tpf_pkg::CFG_X_HIGH, {1'b0, xh});
		write_reg(tpf_pkg::CFG_Y_LOW, {1'b0, yl});
		write_reg(tpf_pkg::CFG_Y_HIGH, {1'b0, yh});
		write_reg(tpf_pkg::CFG_WIDTH, w);
		write_reg(tpf_pkg::CFG_HEIGHT, h);
		write_reg(tpf_pkg::CFG_ORIENT, {7'd0, o});
	endtask

	task automatic random_setup();
		tpf_pkg::field_t a, b;
		a = any_sample();
		b = any_sample();
		load_setup($urandom_range(0, 3) == 0 ? any_sample()
				: tpf_pkg::field_t'($urandom_range(0, 300)),
			($urandom_range(0, 5) == 0) ? b : ((a < b) ? a : b),
			(a < b) ? b : a,
			tpf_pkg::field_t'($urandom_range(0, 1500)),
			tpf_pkg::field_t'($urandom_range(1600, 4095)),
			$urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(1, 1024)),
			$urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(1, 1024)),
			6'($urandom_range(0, 63)));
	endtask

	// one poll: an optional pen check, then Z1, Z2, X, Y; mostly a valid press, sometimes not
	task automatic send_poll();
		tpf_pkg::field_t z1, z2;
		z1 = tpf_pkg::field_t'($urandom_range(cur_thresh, 4095));
		if (z1 > 3900) z1 = 3900;
		z2 = ($urandom_range(0, 3) == 0) ? any_sample()
			: tpf_pkg::field_t'($urandom_range(z1 + 60, 4095));
		if ($urandom_range(0, 3) == 0) send_word(tpf_pkg::KIND_PEN, any_pen(), any_sample(),
			any_sample(), any_sample(), any_sample(), any_sample());
		send_group(tpf_pkg::KIND_Z1, z1);
		send_group(tpf_pkg::KIND_Z2, z2);
		send_group(tpf_pkg::KIND_X, any_sample());
		send_group(tpf_pkg::KIND_Y, any_sample());
	endtask

	task automatic send_noise();
		logic [2:0] k;
		k = $urandom_range(0, 9) == 0 ? 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))
			: 3'($urandom_range(tpf_pkg::KIND_PEN, tpf_pkg::KIND_Y));
		send_word(k, any_pen(), any_sample(), any_sample(), any_sample(), any_sample(),
			any_sample());
	endtask

	initial begin
		in_valid = 1'b0;
		kind = tpf_pkg::KIND_PEN;
		pen_down = 1'b0;
		sample_a = '0;
		sample_b = '0;
		sample_c = '0;
		sample_d = '0;
		sample_e = '0;
		cfg_valid = 1'b0;
		cfg_index = tpf_pkg::CFG_THRESH;
		cfg_data = '0;
		words_sent = 0;
		steady = 1'b0;
		hold_output = 1'b0;
		cur_thresh = '0;
		@(posedge clk iff arst_n);

		// defaults: extremes, full press, unsorted medians, spare kinds
		send_flat(tpf_pkg::KIND_PEN, '0);
		send_flat(tpf_pkg::KIND_Z1, '0);
		send_flat(tpf_pkg::KIND_Z2, '0);
		send_flat(tpf_pkg::KIND_Z1, 12'd4095);
		send_flat(tpf_pkg::KIND_Z2, 12'd4095);
		send_word(tpf_pkg::KIND_Z1, 1'b0, 12'd900, 12'd5, 12'd4095, 12'd100, 12'd800);
		send_word(tpf_pkg::KIND_Z2, 1'b1, 12'd4095, 12'd3000, 12'd0, 12'd2000, 12'd4000);
		send_flat(tpf_pkg::KIND_X, 12'd4095);
		send_flat(tpf_pkg::KIND_Y, 12'd4095);
		send_flat(tpf_pkg::KIND_Y, 12'd100);
		send_word(KIND_SPARE_LO, 1'b1, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5);
		send_word(KIND_SPARE_HI, 1'b0, '0, '0, '0, '0, '0);
		settle();

		// empty raw ranges, out-of-range screen, every orientation bit, pen line
		load_setup(12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 13'd0, 13'd8191, 6'd63);
		send_word(tpf_pkg::KIND_PEN, 1'b0, '0, '0, '0, '0, '0);
		send_word(tpf_pkg::KIND_PEN, 1'b1, '0, '0, '0, '0, '0);
		send_flat(tpf_pkg::KIND_Z1, 12'd4094);
		send_flat(tpf_pkg::KIND_Z2, 12'd4095);
		send_flat(tpf_pkg::KIND_X, 12'd4095);
		send_flat(tpf_pkg::KIND_Y, 12'd0);
		send_flat(tpf_pkg::KIND_Z1, 12'd4095);
		send_flat(tpf_pkg::KIND_Z2, 12'd4095);
		settle();

		load_setup(12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095, 13'd4096, 13'd1, 6'd8);
		send_flat(tpf_pkg::KIND_Z1, 12'd0);
		send_flat(tpf_pkg::KIND_Z2, 12'd1);
		send_flat(tpf_pkg::KIND_X, 12'd2048);
		send_flat(tpf_pkg::KIND_Y, 12'd4095);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			random_setup();
			steady = (phase == 2);
			if (phase == 4) hold_output = 1'b1;
			while (words_sent < 220 * (phase + 1) - 10) begin
				if ($urandom_range(0, 4) == 0) send_noise();
				else send_poll();
			end
			settle();
		end

		steady = 1'b0;
		$display("sent %0d words, checked %0d reports (%0d with a press) over 11 settings",
			words_sent, reports_seen, presses_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
